// ===== rtl/core/rhsk_pkg.sv =====
// shared types and constants of the rgb hue sort key block
`default_nettype none

package rhsk_pkg;

   // channel and result widths
   localparam int CHAN_W = 8;
   localparam int KEY_W  = 25;
   localparam int DVD_W  = 2 * CHAN_W;

   // one division step per cell, one quotient bit per step
   localparam int STEP_COUNT = CHAN_W;

   // hue wheel constants
   localparam logic [CHAN_W-1:0] HUE_SIXTH_SCALE = 8'd43;
   localparam logic [CHAN_W-1:0] HUE_RED_BASE    = 8'd0;
   localparam logic [CHAN_W-1:0] HUE_GREEN_BASE  = 8'd85;
   localparam logic [CHAN_W-1:0] HUE_BLUE_BASE   = 8'd171;

   // one restoring divider lane: partial remainder, unused dividend bits, quotient
   typedef struct packed {
      logic [CHAN_W-1:0] rem;
      logic [CHAN_W-1:0] low;
      logic [CHAN_W-1:0] quo;
   } div_type;

   // everything that travels down the row of cells
   typedef struct packed {
      div_type           hue_lane;
      div_type           sat_lane;
      logic [CHAN_W-1:0] hue_dsr;
      logic [CHAN_W-1:0] sat_dsr;
      logic              hue_neg;
      logic [CHAN_W-1:0] hue_base;
      logic [CHAN_W-1:0] brightness;
      logic              neutral;
   } stage_type;

   // finished result word
   typedef struct packed {
      logic [CHAN_W-1:0] hue;
      logic [CHAN_W-1:0] saturation;
      logic [CHAN_W-1:0] brightness;
      logic              neutral;
      logic [KEY_W-1:0]  sort_key;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/core/rhsk_if.sv =====
// valid/ready channel interfaces for colour words and hsv result words
`default_nettype none

interface rhsk_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rhsk_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  hue;
   logic [7:0]  saturation;
   logic [7:0]  brightness;
   logic        neutral;
   logic [24:0] sort_key;

   modport source (output valid, output hue, output saturation, output brightness,
                   output neutral, output sort_key, input ready);
   modport sink   (input valid, input hue, input saturation, input brightness,
                   input neutral, input sort_key, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rhsk_front.sv =====
// input stage: max, min, chroma, hue sector and divider operands
`default_nettype none

module rhsk_front (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             enable,
   input  wire logic                             req_valid,
   input  wire logic [rhsk_pkg::CHAN_W-1:0]      req_red,
   input  wire logic [rhsk_pkg::CHAN_W-1:0]      req_green,
   input  wire logic [rhsk_pkg::CHAN_W-1:0]      req_blue,
   output logic                                  out_valid,
   output rhsk_pkg::stage_type                   out_data
);

   logic [rhsk_pkg::CHAN_W-1:0] max_val;
   logic [rhsk_pkg::CHAN_W-1:0] min_val;
   logic [rhsk_pkg::CHAN_W-1:0] chroma;
   logic                        red_max;
   logic                        green_max;
   logic [rhsk_pkg::CHAN_W-1:0] op_a;
   logic [rhsk_pkg::CHAN_W-1:0] op_b;
   logic [rhsk_pkg::CHAN_W:0]   diff;
   logic [rhsk_pkg::CHAN_W:0]   diff_neg;
   logic [rhsk_pkg::CHAN_W-1:0] mag;
   logic [rhsk_pkg::DVD_W-1:0]  hue_dvd;
   logic [rhsk_pkg::DVD_W-1:0]  sat_dvd;
   rhsk_pkg::stage_type         data_in;
   rhsk_pkg::stage_type         data_ff;
   logic                        valid_ff;

   // largest and smallest channel, ties go to red then green
   always_comb begin
      red_max   = (req_red >= req_green) && (req_red >= req_blue);
      green_max = !red_max && (req_green >= req_blue);
      if (red_max) begin
         max_val = req_red;
      end else if (green_max) begin
         max_val = req_green;
      end else begin
         max_val = req_blue;
      end
      min_val = req_red;
      if (req_green < min_val) begin
         min_val = req_green;
      end
      if (req_blue < min_val) begin
         min_val = req_blue;
      end
      chroma = max_val - min_val;
   end

   // signed channel difference of the winning sector, split into sign and magnitude
   always_comb begin
      if (red_max) begin
         op_a = req_green;
         op_b = req_blue;
      end else if (green_max) begin
         op_a = req_blue;
         op_b = req_red;
      end else begin
         op_a = req_red;
         op_b = req_green;
      end
      diff     = {1'b0, op_a} - {1'b0, op_b};
      diff_neg = {1'b0, op_b} - {1'b0, op_a};
      mag      = diff[rhsk_pkg::CHAN_W] ? diff_neg[rhsk_pkg::CHAN_W-1:0]
                                        : diff[rhsk_pkg::CHAN_W-1:0];
   end

   // dividends: magnitude times 43 and chroma times 255
   always_comb begin
      hue_dvd = {{rhsk_pkg::CHAN_W{1'b0}}, mag}
              * {{rhsk_pkg::CHAN_W{1'b0}}, rhsk_pkg::HUE_SIXTH_SCALE};
      sat_dvd = {chroma, {rhsk_pkg::CHAN_W{1'b0}}} - {{rhsk_pkg::CHAN_W{1'b0}}, chroma};
   end

   // load both divider lanes, upper dividend half is the starting remainder
   always_comb begin
      data_in.hue_lane.rem = hue_dvd[rhsk_pkg::DVD_W-1:rhsk_pkg::CHAN_W];
      data_in.hue_lane.low = hue_dvd[rhsk_pkg::CHAN_W-1:0];
      data_in.hue_lane.quo = '0;
      data_in.sat_lane.rem = sat_dvd[rhsk_pkg::DVD_W-1:rhsk_pkg::CHAN_W];
      data_in.sat_lane.low = sat_dvd[rhsk_pkg::CHAN_W-1:0];
      data_in.sat_lane.quo = '0;
      data_in.hue_dsr      = chroma;
      data_in.sat_dsr      = max_val;
      data_in.hue_neg      = diff[rhsk_pkg::CHAN_W];
      data_in.brightness   = max_val;
      data_in.neutral      = (chroma == '0);
      if (red_max) begin
         data_in.hue_base = rhsk_pkg::HUE_RED_BASE;
      end else if (green_max) begin
         data_in.hue_base = rhsk_pkg::HUE_GREEN_BASE;
      end else begin
         data_in.hue_base = rhsk_pkg::HUE_BLUE_BASE;
      end
   end

   // stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= req_valid;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/rhsk_cell.sv =====
// one cell of the divider row: a restoring step on the hue and saturation lanes
`default_nettype none

module rhsk_cell (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 enable,
   input  wire logic                 in_valid,
   input  wire rhsk_pkg::stage_type  in_data,
   output logic                      out_valid,
   output rhsk_pkg::stage_type       out_data
);

   rhsk_pkg::stage_type data_in;
   rhsk_pkg::stage_type data_ff;
   logic                valid_ff;

   // shift in the next dividend bit, subtract the divisor when it fits
   function automatic rhsk_pkg::div_type div_step(rhsk_pkg::div_type cur,
                                                  logic [rhsk_pkg::CHAN_W-1:0] dsr);
      logic [rhsk_pkg::CHAN_W:0] trial;
      logic [rhsk_pkg::CHAN_W:0] diff;
      rhsk_pkg::div_type         nxt;
      trial   = {cur.rem, cur.low[rhsk_pkg::CHAN_W-1]};
      diff    = trial - {1'b0, dsr};
      nxt.low = {cur.low[rhsk_pkg::CHAN_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr}) begin
         nxt.rem = diff[rhsk_pkg::CHAN_W-1:0];
         nxt.quo = {cur.quo[rhsk_pkg::CHAN_W-2:0], 1'b1};
      end else begin
         nxt.rem = trial[rhsk_pkg::CHAN_W-1:0];
         nxt.quo = {cur.quo[rhsk_pkg::CHAN_W-2:0], 1'b0};
      end
      return nxt;
   endfunction

   // step both lanes, pass sideband along
   always_comb begin
      data_in          = in_data;
      data_in.hue_lane = div_step(in_data.hue_lane, in_data.hue_dsr);
      data_in.sat_lane = div_step(in_data.sat_lane, in_data.sat_dsr);
   end

   // cell valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   // cell payload
   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/rhsk_back.sv =====
// output stage: signed hue offset, neutral override, sort key, output register
`default_nettype none

module rhsk_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 enable,
   input  wire logic                 in_valid,
   input  wire rhsk_pkg::stage_type  in_data,
   output logic                      out_valid,
   output rhsk_pkg::result_type      out_word
);

   logic [rhsk_pkg::CHAN_W-1:0] hue_q;
   rhsk_pkg::result_type        word_in;
   rhsk_pkg::result_type        word_ff;
   logic                        valid_ff;

   // sector base plus or minus the truncated quotient, wraps mod 256
   always_comb begin
      hue_q = in_data.hue_lane.quo;
      if (in_data.neutral) begin
         word_in.hue        = '0;
         word_in.saturation = '0;
      end else begin
         word_in.hue        = in_data.hue_neg ? (in_data.hue_base - hue_q)
                                              : (in_data.hue_base + hue_q);
         word_in.saturation = in_data.sat_lane.quo;
      end
      word_in.brightness = in_data.brightness;
      word_in.neutral    = in_data.neutral;
      word_in.sort_key   = {in_data.neutral, word_in.hue, ~word_in.saturation,
                            ~in_data.brightness};
   end

   // output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   // output word
   always_ff @(posedge clock) begin
      if (enable) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

`default_nettype wire

// ===== rtl/core/rgb_hue_sort_key_top.sv =====
// rgb hue sort key: 8-bit rgb colour in, integer hsv and packed sort key out
//
// req carries one colour word (red, green, blue) per handshake; rsp carries
// hue, saturation, brightness, neutral and a 25-bit sort key per word.
// An unsigned compare of two sort keys orders colours by hue, then strong
// before washed out, then light before dark, greys last.
// Pipeline: an input stage (max/min/chroma/operands), a row of 8 divider
// cells that each resolve one quotient bit of both the hue and saturation
// divisions, and a registered output stage.
// Throughput: one word per cycle unless the row holds for a stall; the whole row advances together.
// Stall: while rsp.valid is high and rsp.ready low the whole row holds and
// req.ready drops; while rsp.valid is low the row keeps moving.
// Reset: clears every stage valid bit, so rsp.valid is low and nothing is
// in flight; no further setup is needed.
`default_nettype none

module rgb_hue_sort_key_top (
   input  wire logic   clock,
   input  wire logic   reset,
   rhsk_req_if.sink    req,
   rhsk_rsp_if.source  rsp
);

   logic                 advance;
   logic                 stage_valid [0:rhsk_pkg::STEP_COUNT];
   rhsk_pkg::stage_type  stage_data  [0:rhsk_pkg::STEP_COUNT];
   logic                 out_valid;
   rhsk_pkg::result_type out_word;

   // the row moves when the output register is empty or being taken
   assign advance   = !rsp.valid || rsp.ready;
   assign req.ready = advance;

   // operand stage
   rhsk_front u_front (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .req_valid (req.valid),
      .req_red   (req.red),
      .req_green (req.green),
      .req_blue  (req.blue),
      .out_valid (stage_valid[0]),
      .out_data  (stage_data[0])
   );

   // row of divider cells, one quotient bit each
   for (genvar k = 0; k < rhsk_pkg::STEP_COUNT; k++) begin : g_cell
      rhsk_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (advance),
         .in_valid  (stage_valid[k]),
         .in_data   (stage_data[k]),
         .out_valid (stage_valid[k+1]),
         .out_data  (stage_data[k+1])
      );
   end

   // result stage and output register
   rhsk_back u_back (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (stage_valid[rhsk_pkg::STEP_COUNT]),
      .in_data   (stage_data[rhsk_pkg::STEP_COUNT]),
      .out_valid (out_valid),
      .out_word  (out_word)
   );

   assign rsp.valid      = out_valid;
   assign rsp.hue        = out_word.hue;
   assign rsp.saturation = out_word.saturation;
   assign rsp.brightness = out_word.brightness;
   assign rsp.neutral    = out_word.neutral;
   assign rsp.sort_key   = out_word.sort_key;

   // grey words carry no hue and no saturation
   a_neutral_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.neutral) |-> (rsp.hue == '0 && rsp.saturation == '0))
      else $error("neutral word with nonzero hue or saturation");

   // key fields agree with the separate result fields
   a_key_fields: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.sort_key[24] == rsp.neutral
                     && rsp.sort_key[23:16] == rsp.hue
                     && rsp.sort_key[15:8] == ~rsp.saturation
                     && rsp.sort_key[7:0] == ~rsp.brightness))
      else $error("sort key does not match result fields");

   // a taken word is replaced by what stood in the last cell
   a_out_follows_row: assert property (@(posedge clock) disable iff (reset)
      advance |=> (rsp.valid == $past(stage_valid[rhsk_pkg::STEP_COUNT])))
      else $error("output valid lost or invented");

endmodule

`default_nettype wire

// ===== sim/rgb_hue_sort_key_top_tb.sv =====
// self-checking testbench of the rgb hue sort key block: directed and shaped random colours
`default_nettype none

module rgb_hue_sort_key_top_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int BYTE_MAX    = 255;
   localparam int HUE_WRAP    = 256;
   localparam int DRAIN_LIMIT = 4000;
   localparam int SETTLE_CYC  = 12;

   // hsv predictor and in-order store of expected hsv words
   class hsv_scoreboard;
      rhsk_pkg::result_type hsv_q[$];
      int                   errors;

      function new();
         errors = 0;
      endfunction

      function rhsk_pkg::result_type predict_hsv(logic [7:0] r, logic [7:0] g,
                                                 logic [7:0] b);
         int                   ri, gi, bi, mx, mn, chroma, hue, sat, scale;
         logic                 grey;
         rhsk_pkg::result_type res;
         ri = r;
         gi = g;
         bi = b;
         scale = int'(rhsk_pkg::HUE_SIXTH_SCALE);
         mx = ri;
         mn = ri;
         hue = 0;
         sat = 0;
         grey = 1'b0;
         if (gi > mx) mx = gi;
         if (bi > mx) mx = bi;
         if (gi < mn) mn = gi;
         if (bi < mn) mn = bi;
         chroma = mx - mn;
         if (chroma == 0) begin
            grey = 1'b1;
         end else begin
            sat = (chroma * BYTE_MAX) / mx;
            // red wins ties, then green; int division truncates toward zero
            if (mx == ri) begin
               hue = ((gi - bi) * scale) / chroma;
               if (hue < 0) hue += HUE_WRAP;
            end else if (mx == gi) begin
               hue = int'(rhsk_pkg::HUE_GREEN_BASE) + ((bi - ri) * scale) / chroma;
            end else begin
               hue = int'(rhsk_pkg::HUE_BLUE_BASE) + ((ri - gi) * scale) / chroma;
            end
            hue = hue & BYTE_MAX;
         end
         res.hue        = hue[7:0];
         res.saturation = sat[7:0];
         res.brightness = mx[7:0];
         res.neutral    = grey;
         res.sort_key   = {grey, hue[7:0], 8'(BYTE_MAX - sat), 8'(BYTE_MAX - mx)};
         return res;
      endfunction

      function void note_colour(logic [7:0] r, logic [7:0] g, logic [7:0] b);
         hsv_q = {hsv_q, predict_hsv(r, g, b)};
      endfunction

      task report_mismatch(string what, int got, int want);
         $display("[%0t] mismatch %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
         errors++;
      endtask

      task check_result(rhsk_pkg::result_type got);
         rhsk_pkg::result_type want;
         if (hsv_q.size() == 0) begin
            report_mismatch("unexpected word, sort_key", got.sort_key, 0);
         end else begin
            want = hsv_q.pop_front();
            if (got.hue != want.hue)
               report_mismatch("hue", got.hue, want.hue);
            if (got.saturation != want.saturation)
               report_mismatch("saturation", got.saturation, want.saturation);
            if (got.brightness != want.brightness)
               report_mismatch("brightness", got.brightness, want.brightness);
            if (got.neutral != want.neutral)
               report_mismatch("neutral", got.neutral, want.neutral);
            if (got.sort_key != want.sort_key)
               report_mismatch("sort_key", got.sort_key, want.sort_key);
         end
      endtask
   endclass

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   take_idle_pct;

   hsv_scoreboard hsv_sb;

   rhsk_req_if req_ch ();
   rhsk_rsp_if rsp_ch ();

   rgb_hue_sort_key_top u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // clock
   always #4 clock = ~clock;

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= take_idle_pct);
   end

   // watch both handshakes
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            hsv_sb.note_colour(req_ch.red, req_ch.green, req_ch.blue);
         if (rsp_ch.valid && rsp_ch.ready)
            hsv_sb.check_result({rsp_ch.hue, rsp_ch.saturation, rsp_ch.brightness,
                                 rsp_ch.neutral, rsp_ch.sort_key});
      end
   end

   // offer one colour word and hold it until taken, then maybe idle
   task send_colour(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      req_ch.valid <= 1'b1;
      req_ch.red   <= r;
      req_ch.green <= g;
      req_ch.blue  <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
   endtask

   // shaped random colours: mostly free, plus greys, ties, near-greys, extremes
   task run_random(int count);
      logic [7:0] ch [3];
      logic [7:0] picks [6];
      int         shape, sel, base, k;
      picks = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};
      for (int n = 0; n < count; n++) begin
         for (k = 0; k < 3; k++) ch[k] = 8'($urandom_range(BYTE_MAX));
         shape = $urandom_range(9);
         case (shape)
            4: begin
               ch[1] = ch[0];
               ch[2] = ch[0];
            end
            5: begin
               // two channels share the top, the third sits at or below
               sel = $urandom_range(2);
               base = $urandom_range(BYTE_MAX);
               for (k = 0; k < 3; k++) ch[k] = 8'(base);
               ch[sel] = 8'($urandom_range(base));
            end
            6: begin
               base = $urandom_range(BYTE_MAX);
               for (k = 0; k < 3; k++) begin
                  sel = base + $urandom_range(6) - 3;
                  if (sel < 0) sel = 0;
                  if (sel > BYTE_MAX) sel = BYTE_MAX;
                  ch[k] = 8'(sel);
               end
            end
            7: begin
               for (k = 0; k < 3; k++) ch[k] = picks[$urandom_range(5)];
            end
            default: ;
         endcase
         send_colour(ch[0], ch[1], ch[2]);
      end
   endtask

   // hard stop
   initial begin
      #5ms;
      $display("** rgb_hue_sort_key_top: FAILED **");
      $finish;
   end

   // main sequence
   initial begin
      logic [23:0] directed [$];
      int          waited;
      hsv_sb        = new();
      clock         = 1'b0;
      reset         = 1'b1;
      req_ch.valid  = 1'b0;
      req_ch.red    = '0;
      req_ch.green  = '0;
      req_ch.blue   = '0;
      rsp_ch.ready  = 1'b0;
      send_idle_pct = 24;
      take_idle_pct = 62;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // greys, pure primaries, every tie, red wrap, tiny and full chroma
      directed = '{24'h000000, 24'hffffff, 24'h808080, 24'h010101,
                   24'hff0000, 24'h00ff00, 24'h0000ff,
                   24'hffff00, 24'hff00ff, 24'h00ffff, 24'hc8c864, 24'hc864c8,
                   24'h64c8c8, 24'hff000a, 24'hff0100, 24'h010000,
                   24'hfffe00, 24'h0a00ff, 24'h00ff0a, 24'h0aff00,
                   24'h7f80fe, 24'h80ff7f, 24'hfe0001, 24'h000001};
      foreach (directed[i])
         send_colour(directed[i][23:16], directed[i][15:8], directed[i][7:0]);

      run_random(650);
      send_idle_pct = 62;
      take_idle_pct = 24;
      run_random(650);
      send_idle_pct = 0;
      take_idle_pct = 0;
      run_random(650);
      req_ch.valid <= 1'b0;

      // drain what is still in the pipe
      waited = 0;
      while (hsv_sb.hsv_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYC) @(posedge clock);
      foreach (hsv_sb.hsv_q[i])
         hsv_sb.report_mismatch("missing word, sort_key", 0, hsv_sb.hsv_q[i].sort_key);

      if (hsv_sb.errors == 0)
         $display("** rgb_hue_sort_key_top: PASSED **");
      else
         $display("** rgb_hue_sort_key_top: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire

// ===== rgb_hue_sort_key_top.f =====
rtl/core/rhsk_pkg.sv
rtl/core/rhsk_if.sv
rtl/core/rhsk_front.sv
rtl/core/rhsk_cell.sv
rtl/core/rhsk_back.sv
rtl/core/rgb_hue_sort_key_top.sv
sim/rgb_hue_sort_key_top_tb.sv
